// File: src/sprm_pkg.sv
// Package for the bounded stack with push and remove-all-matching.
// Holds sizes, operation and status codes, and the controller/datapath structs.
// No dependencies.
package sprm_pkg;

  localparam int unsigned DEPTH    = 16;
  localparam int unsigned ADDR_W   = $clog2(DEPTH);
  localparam int unsigned CNT_W    = $clog2(DEPTH + 1);
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned ECNT_W   = 5;

  typedef enum logic {
    FUNC_PUSH   = 1'b0,
    FUNC_REMOVE = 1'b1
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic push;       // push value_i, or report full
    logic rem_empty;  // report a remove on an empty stack
    logic load;       // latch the match word, rewind both pointers
    logic read;       // read the entry at the read pointer, advance it
    logic finish;     // commit the compacted count and report
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;      // no entries held
    logic last;       // read pointer is at the top entry
  } dp_stat_t;

endpackage

// File: src/stack_push_remove_all_matching_top.sv
// Bounded stack of signed 32-bit words: push, and remove every matching word.
// Push, or remove on an empty stack: result strobed in the cycle after start; busy stays low.
// Remove on n entries: busy through the scan state (one memory read per entry) and
// the drain state; the result is registered from drain; the next word is taken the cycle busy falls.
// Results are strobed on done_o for one cycle; the receiver cannot stall.
// Reset (rst_ni low, async) empties the stack; entry storage is left as is.
module stack_push_remove_all_matching_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                func_i,
  input  logic signed [sprm_pkg::VALUE_W-1:0] value_i,
  output logic                                done_o,
  output logic [sprm_pkg::STATUS_W-1:0]       status_o,
  output logic [sprm_pkg::ECNT_W-1:0]         entry_count_o
);

  // Command and status buses between the sequencer and the datapath.
  sprm_pkg::dp_cmd_t  cmd;
  sprm_pkg::dp_stat_t stat;

  // Sequencer: takes a word when idle, walks the entries on a remove.
  sprm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .func_i (func_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  // Datapath: one-port-write entry memory with registered read. The remove
  // walk reads at the read pointer and writes survivors at the write pointer,
  // which never passes it, so compaction happens in place.
  sprm_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .value_i       (value_i),
    .stat_o        (stat),
    .done_o        (done_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o)
  );

endmodule

// File: src/sprm_ctrl.sv
// Controller state machine for the stack: sequences push and remove walks.
// Depends on sprm_pkg.
module sprm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               func_i,
  input  sprm_pkg::dp_stat_t stat_i,
  output sprm_pkg::dp_cmd_t  cmd_o,
  output logic               busy
);

  sprm_pkg::state_e state_q, state_d;
  logic             accept;

  assign accept = start && (state_q == sprm_pkg::S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sprm_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      sprm_pkg::S_IDLE: begin
        if (accept && (func_i == sprm_pkg::FUNC_REMOVE) && !stat_i.empty) begin
          state_d = sprm_pkg::S_SCAN;
        end
      end
      sprm_pkg::S_SCAN: begin
        if (stat_i.last) begin
          state_d = sprm_pkg::S_DRAIN;
        end
      end
      sprm_pkg::S_DRAIN: begin
        state_d = sprm_pkg::S_IDLE;
      end
      default: begin
        state_d = sprm_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    case (state_q)
      sprm_pkg::S_IDLE: begin
        busy            = 1'b0;
        cmd_o.push      = accept && (func_i == sprm_pkg::FUNC_PUSH);
        cmd_o.rem_empty = accept && (func_i == sprm_pkg::FUNC_REMOVE) && stat_i.empty;
        cmd_o.load      = accept && (func_i == sprm_pkg::FUNC_REMOVE) && !stat_i.empty;
      end
      sprm_pkg::S_SCAN: begin
        cmd_o.read = 1'b1;
      end
      sprm_pkg::S_DRAIN: begin
        cmd_o.finish = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// File: src/sprm_dp.sv
// Datapath for the stack: entry memory, pointers, count and result register.
// Depends on sprm_pkg.
module sprm_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sprm_pkg::dp_cmd_t                 cmd_i,
  input  logic signed [sprm_pkg::VALUE_W-1:0] value_i,
  output sprm_pkg::dp_stat_t                stat_o,
  output logic                              done_o,
  output logic [sprm_pkg::STATUS_W-1:0]     status_o,
  output logic [sprm_pkg::ECNT_W-1:0]       entry_count_o
);

  logic [sprm_pkg::VALUE_W-1:0] mem [sprm_pkg::DEPTH];
  logic [sprm_pkg::VALUE_W-1:0] rdata_q;
  logic [sprm_pkg::VALUE_W-1:0] val_q;
  logic [sprm_pkg::ADDR_W-1:0]  rd_q, rd_d;
  logic [sprm_pkg::CNT_W-1:0]   wr_q, wr_d;
  logic [sprm_pkg::CNT_W-1:0]   count_q, count_d;
  logic                         rvalid_q;
  logic                         done_q, done_d;
  sprm_pkg::status_e            status_q, status_d;

  logic                         full;
  logic                         keep;
  logic                         mem_we;
  logic [sprm_pkg::ADDR_W-1:0]  mem_waddr;
  logic [sprm_pkg::VALUE_W-1:0] mem_wdata;
  logic [31:0]                  count_ext;

  assign full = (count_q == sprm_pkg::CNT_W'(sprm_pkg::DEPTH));
  // A word read last cycle survives unless it equals the match word.
  assign keep = rvalid_q && (rdata_q != val_q);

  assign mem_we    = (cmd_i.push && !full) || keep;
  assign mem_waddr = cmd_i.push ? count_q[sprm_pkg::ADDR_W-1:0] : wr_q[sprm_pkg::ADDR_W-1:0];
  assign mem_wdata = cmd_i.push ? value_i : rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[rd_q];
    if (cmd_i.load) begin
      val_q <= value_i;
    end
  end

  always_comb begin
    rd_d = rd_q;
    if (cmd_i.load) begin
      rd_d = '0;
    end else if (cmd_i.read) begin
      rd_d = rd_q + sprm_pkg::ADDR_W'(1);
    end
  end

  always_comb begin
    wr_d = wr_q;
    if (cmd_i.load) begin
      wr_d = '0;
    end else if (keep) begin
      wr_d = wr_q + sprm_pkg::CNT_W'(1);
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.push && !full) begin
      count_d = count_q + sprm_pkg::CNT_W'(1);
    end else if (cmd_i.finish) begin
      count_d = wr_d;
    end
  end

  always_comb begin
    done_d   = cmd_i.push || cmd_i.rem_empty || cmd_i.finish;
    status_d = sprm_pkg::ST_OK;
    if (cmd_i.push && full) begin
      status_d = sprm_pkg::ST_FULL;
    end else if (cmd_i.rem_empty) begin
      status_d = sprm_pkg::ST_EMPTY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q     <= '0;
      wr_q     <= '0;
      count_q  <= '0;
      rvalid_q <= 1'b0;
      done_q   <= 1'b0;
      status_q <= sprm_pkg::ST_OK;
    end else begin
      rd_q     <= rd_d;
      wr_q     <= wr_d;
      count_q  <= count_d;
      rvalid_q <= cmd_i.read;
      done_q   <= done_d;
      status_q <= status_d;
    end
  end

  assign stat_o.empty = (count_q == '0);
  assign stat_o.last  = ({1'b0, rd_q} == sprm_pkg::CNT_W'(count_q - sprm_pkg::CNT_W'(1)));

  assign count_ext     = 32'(count_q);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign entry_count_o = count_ext[sprm_pkg::ECNT_W-1:0];

endmodule

// File: src/sprm_chk.sv
// Port-level checker for the stack top level, attached by bind.
// Depends on sprm_pkg and stack_push_remove_all_matching_top.
module sprm_chk (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                start,
  input logic                                busy,
  input logic                                func_i,
  input logic signed [sprm_pkg::VALUE_W-1:0] value_i,
  input logic                                done_o,
  input logic [sprm_pkg::STATUS_W-1:0]       status_o,
  input logic [sprm_pkg::ECNT_W-1:0]         entry_count_o
);

  localparam logic [31:0] DEPTH_W = 32'(sprm_pkg::DEPTH);

  // A push completes in the next cycle.
  a_push_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (func_i == sprm_pkg::FUNC_PUSH)) |=> done_o)
    else $error("push without result in next cycle");

  // A remove walk ends with its result.
  a_walk_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy dropped without result");

  // No result while a walk is still running.
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && $past(busy)) |-> !done_o)
    else $error("result during remove walk");

  a_full_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == sprm_pkg::ST_FULL)) |->
      (entry_count_o == DEPTH_W[sprm_pkg::ECNT_W-1:0]))
    else $error("full status with wrong count");

  a_empty_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == sprm_pkg::ST_EMPTY)) |-> (entry_count_o == '0))
    else $error("empty status with nonzero count");

endmodule

bind stack_push_remove_all_matching_top sprm_chk u_sprm_chk (.*);

// File: tb/sv/tb_stack_push_remove_all_matching_top.sv
// Testbench for stack_push_remove_all_matching_top: pushes and remove-all words
// checked against a predictor of the bounded stack, one result word per input word.
// Depends on sprm_pkg and the top level only.
`timescale 1ns / 100ps

module tb_stack_push_remove_all_matching_top;

  // Expected result of one input word.
  typedef struct packed {
    sprm_pkg::status_e               status;
    logic [sprm_pkg::ECNT_W-1:0]     entry_count;
  } stack_result_t;

  // Track the stack contents and queue the result each accepted word must give.
  class stack_scoreboard;
    logic [sprm_pkg::VALUE_W-1:0] held [sprm_pkg::DEPTH];
    int unsigned                  held_n;
    stack_result_t                expected_results [$];
    int unsigned                  errors;

    function new();
      held_n = 0;
      errors = 0;
    endfunction

    // Apply one accepted word to the predicted stack and queue its result.
    function void note_word(sprm_pkg::func_e f, logic [sprm_pkg::VALUE_W-1:0] v);
      stack_result_t r;
      int unsigned   wr;
      r.status = sprm_pkg::ST_OK;
      if (f == sprm_pkg::FUNC_PUSH) begin
        if (held_n >= sprm_pkg::DEPTH) begin
          r.status = sprm_pkg::ST_FULL;
        end else begin
          held[held_n] = v;
          held_n++;
        end
      end else if (held_n == 0) begin
        r.status = sprm_pkg::ST_EMPTY;
      end else begin
        // Compact the survivors downward, keeping bottom-to-top order.
        wr = 0;
        for (int unsigned rd = 0; rd < held_n; rd++) begin
          if (held[rd] !== v) begin
            held[wr] = held[rd];
            wr++;
          end
        end
        held_n = wr;
      end
      r.entry_count = held_n[sprm_pkg::ECNT_W-1:0];
      expected_results.push_back(r);
    endfunction

    // Compare one strobed result with the oldest expectation.
    function void check_result(logic [sprm_pkg::STATUS_W-1:0] st,
                               logic [sprm_pkg::ECNT_W-1:0] cnt);
      stack_result_t e;
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected: status %0d entry_count %0d", st, cnt);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      if (st !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, st);
        errors++;
      end
      if (cnt !== e.entry_count) begin
        $error("entry_count: expected %0d, got %0d", e.entry_count, cnt);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction
  endclass

  logic                                clk_i   = 1'b0;
  logic                                rst_ni  = 1'b0;
  logic                                start   = 1'b0;
  logic                                func_i  = 1'b0;
  logic signed [sprm_pkg::VALUE_W-1:0] value_i = '0;
  logic                                busy;
  logic                                done_o;
  logic [sprm_pkg::STATUS_W-1:0]       status_o;
  logic [sprm_pkg::ECNT_W-1:0]         entry_count_o;

  stack_scoreboard model = new();

  stack_push_remove_all_matching_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .func_i        (func_i),
    .value_i       (value_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o)
  );

  always #4 clk_i = ~clk_i;

  // Results cannot be held off: take every strobed word at the edge that ends it.
  always @(posedge clk_i) begin
    if (done_o) begin
      model.check_result(status_o, entry_count_o);
    end
  end

  // Issue one word: optionally idle first, then hold start until busy is low at an edge.
  // Every path ends right after an edge, so start is assigned once per time step.
  task automatic issue_word(sprm_pkg::func_e f, logic [sprm_pkg::VALUE_W-1:0] v,
                            bit may_idle);
    if (may_idle) begin
      while ($urandom_range(99) < 36) begin
        start <= 1'b0;
        @(posedge clk_i);
      end
    end
    start  <= 1'b1;
    func_i <= f;
    value_i <= v;
    do @(posedge clk_i); while (busy);
    model.note_word(f, v);
  endtask

  // Drop start and wait until every expected result has come back.
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (model.pending() != 0);
  endtask

  initial begin
    logic [sprm_pkg::VALUE_W-1:0] pool [6];
    logic [sprm_pkg::VALUE_W-1:0] v;
    sprm_pkg::func_e              f;
    bit                           filling;
    int                           epoch_left;

    filling    = 1'b0;
    epoch_left = 0;

    // Hold reset, then release it at an edge.
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: remove on empty, field extremes, fill to full, push when full,
    // remove with no match, and a remove that deletes many scattered entries.
    issue_word(sprm_pkg::FUNC_REMOVE, 32'h0000_0000, 1'b1);
    issue_word(sprm_pkg::FUNC_PUSH,   32'h7FFF_FFFF, 1'b1);
    issue_word(sprm_pkg::FUNC_PUSH,   32'h8000_0000, 1'b1);
    issue_word(sprm_pkg::FUNC_PUSH,   32'h0000_0000, 1'b1);
    issue_word(sprm_pkg::FUNC_PUSH,   32'hFFFF_FFFF, 1'b1);
    // Zero differs from the minimum only in the sign bit: only zero goes.
    issue_word(sprm_pkg::FUNC_REMOVE, 32'h0000_0000, 1'b1);
    // Differs from the maximum only in bit 0: nothing matches.
    issue_word(sprm_pkg::FUNC_REMOVE, 32'h7FFF_FFFE, 1'b1);
    for (int k = 0; k < 13; k++) begin
      issue_word(sprm_pkg::FUNC_PUSH, (k % 2 == 0) ? 32'd5 : 32'hFFFF_FFFE, 1'b0);
    end
    issue_word(sprm_pkg::FUNC_PUSH,   32'h1234_5678, 1'b1);
    issue_word(sprm_pkg::FUNC_REMOVE, 32'd5,         1'b1);
    issue_word(sprm_pkg::FUNC_REMOVE, 32'hFFFF_FFFE, 1'b1);

    // Let the directed results land before the random part.
    wait_drained();

    // Random part: values mostly from a small pool so removes hit repeated entries;
    // alternate fill-biased and drain-biased epochs to reach both full and empty.
    for (int k = 0; k < 6; k++) begin
      pool[k] = $urandom;
    end
    for (int i = 0; i < 1900; i++) begin
      if (epoch_left == 0) begin
        filling    = ~filling;
        epoch_left = $urandom_range(60, 10);
      end
      epoch_left--;
      if ($urandom_range(15) == 0) begin
        pool[$urandom_range(5)] = $urandom;
      end
      f = ($urandom_range(99) < (filling ? 80 : 30)) ? sprm_pkg::FUNC_PUSH
                                                     : sprm_pkg::FUNC_REMOVE;
      v = ($urandom_range(9) == 0) ? 32'($urandom) : pool[$urandom_range(5)];
      // Pause the sender now and then until the block has answered everything.
      if (i == 400 || i == 1300) begin
        wait_drained();
      end
      // Keep one long stretch free of sender gaps.
      issue_word(f, v, !(i >= 700 && i < 1000));
    end

    // Drop start, drain, then keep checking for stray results before the verdict.
    wait_drained();
    repeat (4 * sprm_pkg::DEPTH) @(posedge clk_i);

    if (model.errors == 0) begin
      $display("[stack_push_remove_all_matching_top] OK");
    end else begin
      $display("[stack_push_remove_all_matching_top] ERROR");
    end
    $finish;
  end

  // Stop a hung run well past the slowest correct one.
  initial begin
    #5_000_000;
    $display("[stack_push_remove_all_matching_top] ERROR");
    $finish;
  end

endmodule
